// ===== hdl/s2du_pkg.sv =====
package s2du_pkg;

  localparam int WORDS_PER_FRAME = 16;
  localparam int FRAMES_DEF      = 7;

  localparam int WORD_W  = 32;
  localparam int WIDX_W  = 4;
  localparam int CTRL_W  = 30;
  localparam int CNT_W   = 3;

  // Steim2 control codes.
  localparam logic [1:0] CODE_NONE = 2'd0;
  localparam logic [1:0] CODE_ONE  = 2'd1;
  localparam logic [1:0] CODE_TWO  = 2'd2;
  localparam logic [1:0] CODE_THR  = 2'd3;

  // Subcodes held in bits 31:30 of a data word.
  localparam logic [1:0] SUB_0 = 2'd0;
  localparam logic [1:0] SUB_1 = 2'd1;
  localparam logic [1:0] SUB_2 = 2'd2;
  localparam logic [1:0] SUB_3 = 2'd3;

  typedef logic [2:0] fmt_t;

  // Packing formats of a word that yields samples.
  localparam fmt_t FMT_INIT = 3'd0;
  localparam fmt_t FMT_4X8  = 3'd1;
  localparam fmt_t FMT_1X30 = 3'd2;
  localparam fmt_t FMT_2X15 = 3'd3;
  localparam fmt_t FMT_3X10 = 3'd4;
  localparam fmt_t FMT_5X6  = 3'd5;
  localparam fmt_t FMT_6X5  = 3'd6;
  localparam fmt_t FMT_7X4  = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    fmt_t              fmt;
  } s2du_item_t;

  // Number of samples carried by a word of the given format.
  function automatic logic [CNT_W-1:0] fmt_count(input fmt_t fmt);
    logic [CNT_W-1:0] n;
    case (fmt)
      FMT_INIT: n = 3'd1;
      FMT_4X8:  n = 3'd4;
      FMT_1X30: n = 3'd1;
      FMT_2X15: n = 3'd2;
      FMT_3X10: n = 3'd3;
      FMT_5X6:  n = 3'd5;
      FMT_6X5:  n = 3'd6;
      FMT_7X4:  n = 3'd7;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  // Sample k of a word, most significant field first, sign-extended.
  function automatic logic [WORD_W-1:0] unpack_field(input logic [WORD_W-1:0] w,
                                                     input fmt_t fmt,
                                                     input logic [CNT_W-1:0] k);
    logic [4:0]        sh;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] res;
    sh  = 5'd0;
    t   = w;
    res = w;
    case (fmt)
      FMT_INIT: res = w;
      FMT_4X8: begin
        sh  = 5'((3 - int'(k)) * 8);
        t   = w >> sh;
        res = {{24{t[7]}}, t[7:0]};
      end
      FMT_1X30: res = {{2{w[29]}}, w[29:0]};
      FMT_2X15: begin
        sh  = 5'((1 - int'(k)) * 15);
        t   = w >> sh;
        res = {{17{t[14]}}, t[14:0]};
      end
      FMT_3X10: begin
        sh  = 5'((2 - int'(k)) * 10);
        t   = w >> sh;
        res = {{22{t[9]}}, t[9:0]};
      end
      FMT_5X6: begin
        sh  = 5'((4 - int'(k)) * 6);
        t   = w >> sh;
        res = {{26{t[5]}}, t[5:0]};
      end
      FMT_6X5: begin
        sh  = 5'((5 - int'(k)) * 5);
        t   = w >> sh;
        res = {{27{t[4]}}, t[4:0]};
      end
      FMT_7X4: begin
        sh  = 5'((6 - int'(k)) * 4);
        t   = w >> sh;
        res = {{28{t[3]}}, t[3:0]};
      end
      default: res = w;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/s2du_if.sv =====
interface s2du_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        start_of_record;

  modport source (output valid, output data_word, output start_of_record, input ready);
  modport sink   (input valid, input data_word, input start_of_record, output ready);
endinterface

interface s2du_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               is_initial_value;
  logic               last_of_word;

  modport source (output valid, output sample, output is_initial_value,
                  output last_of_word, input ready);
  modport sink   (input valid, input sample, input is_initial_value,
                  input last_of_word, output ready);
endinterface

// ===== hdl/steim2_difference_unpacker.sv =====
// Steim2 difference unpacker.
// The input channel (in_ch) carries the 32-bit data words of a compressed
// record, one word per item, with start_of_record marking word 0 of frame 0.
// The result channel (out_ch) carries one sample per item: a sign-extended
// difference, or the record's initial value flagged by is_initial_value, with
// last_of_word set on the final sample taken from a word.
// Control words, the last-value word of frame 0, words with code 0 and words
// with an unknown subcode are consumed and give no result.
// A sample passes through the word register, then the result register.
// Throughput: one sample per cycle while words arrive and the receiver is
// ready; a word of n samples stays in the word register until its last one
// moves on. Words that yield nothing do not enter the word register.
// When the receiver stalls, the result register holds its sample and the word
// register holds the word being unpacked; in_ch.ready is low while the word
// register holds a word, except while its last sample moves on.
// Reset (synchronous, rst_n low) empties both registers and returns the word
// and frame counters and the stored control codes to zero.
module steim2_difference_unpacker #(
  parameter int FRAMES = s2du_pkg::FRAMES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  s2du_in_if.sink    in_ch,
  s2du_out_if.source out_ch
);
  import s2du_pkg::*;

  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAMES - 1);

  logic [CTRL_W-1:0]  ctrl_r, ctrl_nxt;
  logic [WIDX_W-1:0]  widx_r, widx_nxt;
  logic [FRAME_W-1:0] fidx_r, fidx_nxt;

  logic               accept;
  logic               can_load;
  logic               load;
  s2du_item_t         load_item;

  // Position of the current word, after a start-of-record restart.
  logic [WIDX_W-1:0]  wi;
  logic [FRAME_W-1:0] fi;
  logic [4:0]         code_pos;
  logic [CTRL_W-1:0]  ctrl_shift;
  logic [1:0]         code;
  logic [1:0]         sub;
  logic               has_data;
  fmt_t               fmt;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && in_ch.ready;

  assign wi = in_ch.start_of_record ? '0 : widx_r;
  assign fi = in_ch.start_of_record ? '0 : fidx_r;

  // The code of word w sits at bit (15 - w) * 2 of the stored control bits.
  assign code_pos   = 5'(2 * (15 - int'(wi)));
  assign ctrl_shift = ctrl_r >> code_pos;
  assign code       = ctrl_shift[1:0];
  assign sub        = in_ch.data_word[31:30];

  always_comb begin
    has_data = 1'b0;
    fmt      = FMT_INIT;
    if (wi == '0) begin
      has_data = 1'b0;
    end else if (fi == '0 && wi == 4'd1) begin
      has_data = 1'b1;
      fmt      = FMT_INIT;
    end else if (fi == '0 && wi == 4'd2) begin
      // Last value of the record: not emitted.
      has_data = 1'b0;
    end else begin
      case (code)
        CODE_NONE: has_data = 1'b0;
        CODE_ONE: begin
          has_data = 1'b1;
          fmt      = FMT_4X8;
        end
        CODE_TWO: begin
          case (sub)
            SUB_1: begin has_data = 1'b1; fmt = FMT_1X30; end
            SUB_2: begin has_data = 1'b1; fmt = FMT_2X15; end
            SUB_3: begin has_data = 1'b1; fmt = FMT_3X10; end
            default: has_data = 1'b0;
          endcase
        end
        CODE_THR: begin
          case (sub)
            SUB_0: begin has_data = 1'b1; fmt = FMT_5X6; end
            SUB_1: begin has_data = 1'b1; fmt = FMT_6X5; end
            SUB_2: begin has_data = 1'b1; fmt = FMT_7X4; end
            default: has_data = 1'b0;
          endcase
        end
        default: has_data = 1'b0;
      endcase
    end
  end

  assign load           = accept && has_data;
  assign load_item.word = in_ch.data_word;
  assign load_item.fmt  = fmt;

  // Counters advance on every accepted word; the record wraps after its last frame.
  always_comb begin
    ctrl_nxt = ctrl_r;
    widx_nxt = widx_r;
    fidx_nxt = fidx_r;
    if (accept) begin
      if (wi == '0) begin
        ctrl_nxt = in_ch.data_word[CTRL_W-1:0];
      end
      widx_nxt = wi + 4'd1;
      fidx_nxt = fi;
      if (wi == 4'(WORDS_PER_FRAME - 1)) begin
        fidx_nxt = (fi == FRAME_LAST) ? '0 : fi + FRAME_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
      widx_r <= '0;
      fidx_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
      widx_r <= widx_nxt;
      fidx_r <= fidx_nxt;
    end
  end

  s2du_word_stage u_word_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_item (load_item),
    .can_load  (can_load),
    .out_ch    (out_ch)
  );

endmodule

// ===== hdl/s2du_word_stage.sv =====
module s2du_word_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  s2du_pkg::s2du_item_t load_item,
  output logic                can_load,
  s2du_out_if.source          out_ch
);
  import s2du_pkg::*;

  logic              wv_r, wv_nxt;
  s2du_item_t        item_r, item_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              ov_r, ov_nxt;
  logic [WORD_W-1:0] smp_r, smp_nxt;
  logic              init_r, init_nxt;
  logic              last_r, last_nxt;
  logic              adv;
  logic              is_last;

  assign is_last  = (k_r == fmt_count(item_r.fmt) - 3'd1);
  assign adv      = wv_r && (!ov_r || out_ch.ready);
  assign can_load = !wv_r || (adv && is_last);

  always_comb begin
    wv_nxt   = wv_r;
    item_nxt = item_r;
    k_nxt    = k_r;
    if (load) begin
      wv_nxt   = 1'b1;
      item_nxt = load_item;
      k_nxt    = '0;
    end else if (adv && is_last) begin
      wv_nxt = 1'b0;
    end else if (adv) begin
      k_nxt = k_r + 3'd1;
    end

    ov_nxt   = ov_r;
    smp_nxt  = smp_r;
    init_nxt = init_r;
    last_nxt = last_r;
    if (adv) begin
      ov_nxt   = 1'b1;
      smp_nxt  = unpack_field(item_r.word, item_r.fmt, k_r);
      init_nxt = (item_r.fmt == FMT_INIT);
      last_nxt = is_last;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= 1'b0;
      ov_r <= 1'b0;
      k_r  <= '0;
    end else begin
      wv_r <= wv_nxt;
      ov_r <= ov_nxt;
      k_r  <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    smp_r  <= smp_nxt;
    init_r <= init_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.sample           = $signed(smp_r);
  assign out_ch.is_initial_value = init_r;
  assign out_ch.last_of_word     = last_r;

endmodule
